@@ hw/rtl/dmarc_pkg.sv @@
// Shared types, character codes and helper functions for the DMARC record parser.
`timescale 1ns / 1ps

package dmarc_pkg;

    // Character codes
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Version token, first character in the top byte
    localparam logic [63:0] VERSION_TEXT = "v=DMARC1";
    localparam logic [3:0]  VERSION_LEN  = 4'd8;

    // Token buffer sizes
    localparam logic [2:0] NAME_CAP  = 3'd5;
    localparam logic [3:0] VALUE_CAP = 4'd10;

    // Percentage handling
    localparam logic [7:0] PCT_BAD     = 8'd255;
    localparam logic [7:0] PCT_MAX     = 8'd100;
    localparam logic [6:0] PCT_DEFAULT = 7'd100;

    // Policy classes held between tokens
    localparam logic [2:0] CLS_ABSENT  = 3'd0;
    localparam logic [2:0] CLS_INVALID = 3'd1;
    localparam logic [2:0] CLS_NONE    = 3'd2;
    localparam logic [2:0] CLS_QUAR    = 3'd3;
    localparam logic [2:0] CLS_REJECT  = 3'd4;

    // Token being collected; buffers shift in at index 0, so the
    // first character sits at the highest used index
    typedef struct packed {
        logic [4:0][7:0] name;
        logic [2:0]      name_len;
        logic [9:0][7:0] value;
        logic [3:0]      value_len;
        logic [1:0]      overflow;   // bit0 name, bit1 value
        logic [7:0]      pct;
    } token_t;

    // Classification of a finished tag token
    typedef struct packed {
        logic       is_p;
        logic       is_sp;
        logic       is_adkim;
        logic       is_aspf;
        logic       is_pct;
        logic [2:0] policy;
        logic       value_is_s;
        logic       pct_ok;
    } tag_class_t;

    // One parsed record
    typedef struct packed {
        logic       record_valid;
        logic [1:0] domain_policy;
        logic [1:0] subdomain_policy;
        logic       has_subdomain_policy;
        logic       dkim_strict;
        logic       spf_strict;
        logic [6:0] percent;
    } dmarc_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c + CASE_DELTA) : c;
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] idx);
        return VERSION_TEXT[{~idx, 3'b000} +: 8];
    endfunction

endpackage

@@ hw/rtl/dmarc_stream_if.sv @@
// Valid/ready channel interfaces for record bytes and parsed results.
`timescale 1ns / 1ps

interface dmarc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface dmarc_result_if;
    logic       valid;
    logic       ready;
    logic       record_valid;
    logic [1:0] domain_policy;
    logic [1:0] subdomain_policy;
    logic       has_subdomain_policy;
    logic       dkim_strict;
    logic       spf_strict;
    logic [6:0] percent;

    modport source (output valid, output record_valid, output domain_policy,
                    output subdomain_policy, output has_subdomain_policy,
                    output dkim_strict, output spf_strict, output percent,
                    input ready);
    modport sink   (input valid, input record_valid, input domain_policy,
                    input subdomain_policy, input has_subdomain_policy,
                    input dkim_strict, input spf_strict, input percent,
                    output ready);
endinterface

@@ hw/rtl/dmarc_tag_classify.sv @@
// Keyword matching of a finished tag token: tag name, policy value, strict flag, pct.
`timescale 1ns / 1ps

module dmarc_tag_classify
    import dmarc_pkg::*;
(
    input  token_t     tok,
    output tag_class_t cls
);

    logic [9:0][7:0] value_lc;
    logic            name_ok;
    logic            value_ok;
    logic [2:0]      policy_cls;

    // Lowercase copy of the value buffer
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            value_lc[i] = to_lower(tok.value[i]);
        end
    end

    assign name_ok  = !tok.overflow[0];
    assign value_ok = !tok.overflow[1];

    // Tag names are stored lowercase already
    assign cls.is_p     = name_ok && (tok.name_len == 3'd1) && (tok.name[0] == "p");
    assign cls.is_sp    = name_ok && (tok.name_len == 3'd2) && (tok.name[1:0] == "sp");
    assign cls.is_pct   = name_ok && (tok.name_len == 3'd3) && (tok.name[2:0] == "pct");
    assign cls.is_aspf  = name_ok && (tok.name_len == 3'd4) && (tok.name[3:0] == "aspf");
    assign cls.is_adkim = name_ok && (tok.name_len == 3'd5) && (tok.name[4:0] == "adkim");

    // Policy value
    always_comb
    begin
        priority if (value_ok && (tok.value_len == 4'd4) && (value_lc[3:0] == "none"))
        begin
            policy_cls = CLS_NONE;
        end
        else if (value_ok && (tok.value_len == 4'd10) && (value_lc[9:0] == "quarantine"))
        begin
            policy_cls = CLS_QUAR;
        end
        else if (value_ok && (tok.value_len == 4'd6) && (value_lc[5:0] == "reject"))
        begin
            policy_cls = CLS_REJECT;
        end
        else
        begin
            policy_cls = CLS_INVALID;
        end
    end

    assign cls.policy     = policy_cls;
    assign cls.value_is_s = value_ok && (tok.value_len == 4'd1) && (value_lc[0] == "s");
    assign cls.pct_ok     = (tok.value_len != 4'd0) && (tok.pct <= PCT_MAX);

endmodule

@@ hw/rtl/dmarc_tag_parser.sv @@
// Per-byte record parser: version check, token collection and tag state.
`timescale 1ns / 1ps

module dmarc_tag_parser
    import dmarc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    text_byte,
    input  logic          last_byte,
    output logic          done,
    output dmarc_result_t result
);

    typedef enum logic [1:0] {
        PH_VERSION = 2'd0,
        PH_NAME    = 2'd1,
        PH_VALUE   = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_upd;
    logic [3:0] vcount_reg, vcount_upd;
    logic       vmis_reg, vmis_upd, vmis_end;
    token_t     tok_reg, tok_upd;
    logic       pend_reg, pend_upd;
    logic [2:0] pcls_reg, pcls_end;
    logic [2:0] scls_reg, scls_end;
    logic [1:0] align_reg, align_end;
    logic [6:0] pheld_reg, pheld_end;

    logic       is_semi;
    logic       is_ws;
    logic       is_digit;
    logic       end_tok;
    logic [2:0] pol_d;
    logic [2:0] pol_s;
    logic       rec_ok;
    logic       sub_ok;
    tag_class_t cls;

    assign is_semi  = (text_byte == CH_SEMI);
    assign is_ws    = is_space(text_byte);
    assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign end_tok  = is_semi || last_byte;

    // Take one byte into the open token (a semicolon leaves it as is)
    always_comb
    begin
        logic [9:0] pct_sum;
        logic [7:0] pct_tmp;
        pct_sum    = '0;
        pct_tmp    = tok_reg.pct;
        phase_upd  = phase_reg;
        vcount_upd = vcount_reg;
        vmis_upd   = vmis_reg;
        tok_upd    = tok_reg;
        pend_upd   = pend_reg;
        if (!is_semi)
        begin
            unique case (phase_reg)
                PH_VERSION:
                begin
                    if (!is_ws)
                    begin
                        if ((vcount_reg < VERSION_LEN)
                            && (text_byte == version_char(vcount_reg[2:0])))
                        begin
                            vcount_upd = vcount_reg + 4'd1;
                        end
                        else
                        begin
                            vmis_upd = 1'b1;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (text_byte == CH_EQUALS)
                    begin
                        phase_upd = PH_VALUE;
                        pend_upd  = 1'b0;
                    end
                    else if (is_ws)
                    begin
                        if (tok_reg.name_len != 3'd0)
                        begin
                            pend_upd = 1'b1;
                        end
                    end
                    else if (pend_reg || (tok_reg.name_len >= NAME_CAP))
                    begin
                        tok_upd.overflow[0] = 1'b1;
                    end
                    else
                    begin
                        tok_upd.name     = {tok_reg.name[3:0], to_lower(text_byte)};
                        tok_upd.name_len = tok_reg.name_len + 3'd1;
                    end
                end
                PH_VALUE:
                begin
                    if (is_ws)
                    begin
                        if (tok_reg.value_len != 4'd0)
                        begin
                            pend_upd = 1'b1;
                        end
                    end
                    else
                    begin
                        // inner whitespace spoils the value
                        if (pend_reg)
                        begin
                            tok_upd.overflow[1] = 1'b1;
                            pct_tmp             = PCT_BAD;
                        end
                        // decimal accumulation, times ten as shift-and-add
                        if (is_digit)
                        begin
                            if (pct_tmp <= PCT_MAX)
                            begin
                                pct_sum = {pct_tmp[6:0], 3'b000}
                                        + {2'b00, pct_tmp[6:0], 1'b0}
                                        + {6'd0, text_byte[3:0]};
                                tok_upd.pct = (pct_sum > {2'b00, PCT_MAX}) ?
                                              PCT_BAD : pct_sum[7:0];
                            end
                            else
                            begin
                                tok_upd.pct = pct_tmp;
                            end
                        end
                        else
                        begin
                            tok_upd.pct = PCT_BAD;
                        end
                        if (tok_reg.value_len < VALUE_CAP)
                        begin
                            tok_upd.value     = {tok_reg.value[8:0], text_byte};
                            tok_upd.value_len = tok_reg.value_len + 4'd1;
                        end
                        else
                        begin
                            tok_upd.overflow[1] = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase
        end
    end

    dmarc_tag_classify u_classify (
        .tok (tok_upd),
        .cls (cls)
    );

    // Close the token on a semicolon or the last byte; unknown tags change nothing
    always_comb
    begin
        vmis_end  = vmis_upd;
        pcls_end  = pcls_reg;
        scls_end  = scls_reg;
        align_end = align_reg;
        pheld_end = pheld_reg;
        if (end_tok)
        begin
            if ((phase_upd == PH_VERSION) && (vcount_upd != VERSION_LEN))
            begin
                vmis_end = 1'b1;
            end
            if (phase_upd == PH_VALUE)
            begin
                if (cls.is_p)
                begin
                    pcls_end = cls.policy;
                end
                else if (cls.is_sp)
                begin
                    scls_end = cls.policy;
                end
                else if (cls.is_adkim)
                begin
                    align_end[0] = cls.value_is_s;
                end
                else if (cls.is_aspf)
                begin
                    align_end[1] = cls.value_is_s;
                end
                else if (cls.is_pct)
                begin
                    pheld_end = cls.pct_ok ? tok_upd.pct[6:0] : PCT_DEFAULT;
                end
            end
        end
    end

    // Result fields, defaults when the record is invalid
    assign rec_ok = !vmis_end && (pcls_end >= CLS_NONE);
    assign sub_ok = rec_ok && (scls_end >= CLS_NONE);
    assign pol_d  = pcls_end - CLS_NONE;
    assign pol_s  = scls_end - CLS_NONE;

    assign result.record_valid         = rec_ok;
    assign result.domain_policy        = rec_ok ? pol_d[1:0] : 2'd0;
    assign result.subdomain_policy     = sub_ok ? pol_s[1:0] : 2'd0;
    assign result.has_subdomain_policy = sub_ok;
    assign result.dkim_strict          = rec_ok && align_end[0];
    assign result.spf_strict           = rec_ok && align_end[1];
    assign result.percent              = rec_ok ? pheld_end : PCT_DEFAULT;
    assign done                        = step && last_byte;

    // Parser state; the last byte returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_VERSION;
            vcount_reg <= '0;
            vmis_reg   <= 1'b0;
            tok_reg    <= '0;
            pend_reg   <= 1'b0;
            pcls_reg   <= CLS_ABSENT;
            scls_reg   <= CLS_ABSENT;
            align_reg  <= '0;
            pheld_reg  <= PCT_DEFAULT;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg  <= PH_VERSION;
                vcount_reg <= '0;
                vmis_reg   <= 1'b0;
                tok_reg    <= '0;
                pend_reg   <= 1'b0;
                pcls_reg   <= CLS_ABSENT;
                scls_reg   <= CLS_ABSENT;
                align_reg  <= '0;
                pheld_reg  <= PCT_DEFAULT;
            end
            else
            begin
                if (end_tok)
                begin
                    phase_reg <= PH_NAME;
                    tok_reg   <= '0;
                    pend_reg  <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_upd;
                    tok_reg   <= tok_upd;
                    pend_reg  <= pend_upd;
                end
                vcount_reg <= vcount_upd;
                vmis_reg   <= vmis_end;
                pcls_reg   <= pcls_end;
                scls_reg   <= scls_end;
                align_reg  <= align_end;
                pheld_reg  <= pheld_end;
            end
        end
    end

endmodule

@@ hw/rtl/dmarc_record_parser.sv @@
// Top level of the DMARC record parser: input register, parser and result register.
//
// Usage:
//   rec_bytes carries the record text one byte per request, with last_byte
//   set on the final character. rec_result carries one parsed record per
//   request: validity, domain and subdomain policy, alignment flags, percent.
//   Throughput is one byte per cycle while no last byte waits (see below).
//   A byte is held in the input register and is then consumed by the parser;
//   the result of a record is loaded into the result register at the edge
//   where its last byte leaves the input register, and is presented from
//   there until it is taken.
//   The result register holds a finished record while the receiver stalls;
//   bytes of the next record keep flowing. Only a further last byte waits in
//   the input register until the held result is taken, and rec_bytes.ready
//   drops for as long.
//   After reset (rst_n low, asynchronous) both registers are empty and the
//   parser waits for the version token of a new record; after each last
//   byte it returns to that state on its own.
`timescale 1ns / 1ps

module dmarc_record_parser
    import dmarc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dmarc_byte_if.sink            rec_bytes,
    dmarc_result_if.source        rec_result
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          advance;
    logic          core_done;
    dmarc_result_t core_result;
    logic          out_valid_reg;
    dmarc_result_t out_data_reg;

    // A last byte may leave only when the result register is free
    assign advance = in_valid_reg
                     && !(in_last_reg && out_valid_reg && !rec_result.ready);
    assign rec_bytes.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rec_bytes.ready)
        begin
            in_valid_reg <= rec_bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_bytes.valid && rec_bytes.ready)
        begin
            in_byte_reg <= rec_bytes.text_byte;
            in_last_reg <= rec_bytes.last_byte;
        end
    end

    dmarc_tag_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .done      (core_done),
        .result    (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rec_result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            out_data_reg <= core_result;
        end
    end

    assign rec_result.valid                = out_valid_reg;
    assign rec_result.record_valid         = out_data_reg.record_valid;
    assign rec_result.domain_policy        = out_data_reg.domain_policy;
    assign rec_result.subdomain_policy     = out_data_reg.subdomain_policy;
    assign rec_result.has_subdomain_policy = out_data_reg.has_subdomain_policy;
    assign rec_result.dkim_strict          = out_data_reg.dkim_strict;
    assign rec_result.spf_strict           = out_data_reg.spf_strict;
    assign rec_result.percent              = out_data_reg.percent;

    // A finished record never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> (!out_valid_reg || rec_result.ready))
        else $error("result register overwritten while held");

    // A byte stuck in the input register stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg)))
        else $error("stalled input byte lost");

    // Invalid records carry default fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_result.valid && !rec_result.record_valid) |->
            ((rec_result.domain_policy == 2'd0) && !rec_result.has_subdomain_policy
             && !rec_result.dkim_strict && !rec_result.spf_strict
             && (rec_result.percent == PCT_DEFAULT)))
        else $error("invalid record with non-default fields");

    // Policy codes and percent stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_result.valid |->
            ((rec_result.domain_policy != 2'd3) && (rec_result.subdomain_policy != 2'd3)
             && (rec_result.percent <= PCT_DEFAULT)
             && (rec_result.has_subdomain_policy || (rec_result.subdomain_policy == 2'd0))))
        else $error("result field out of range");

endmodule

@@ sim/tb_dmarc_record_parser.sv @@
// Testbench for dmarc_record_parser: directed and random records against a byte-level predictor.
`timescale 1ns / 1ps

module tb_dmarc_record_parser;
    import dmarc_pkg::*;

    localparam int BYTE_TARGET   = 1100;
    localparam int RECORD_TARGET = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 20;

    typedef enum logic [1:0] {PH_VERSION, PH_NAME, PH_VALUE} scan_phase_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG} rx_mode_t;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       wait_idle;   // hold this request until no record is outstanding
    } text_item_t;

    // Clock, reset and the driven copies of the block inputs
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       tx_valid = 1'b0;
    logic [7:0] tx_text  = 8'h00;
    logic       tx_last  = 1'b0;
    logic       rx_ready = 1'b0;

    dmarc_byte_if   byte_ch ();
    dmarc_result_if result_ch ();

    assign byte_ch.valid     = tx_valid;
    assign byte_ch.text_byte = tx_text;
    assign byte_ch.last_byte = tx_last;
    assign result_ch.ready   = rx_ready;

    dmarc_record_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_bytes  (byte_ch),
        .rec_result (result_ch)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Request backlog and expected parsed records
    text_item_t    text_backlog[$];
    dmarc_result_t expected_records[$];
    logic [7:0]    draft[$];
    int            records_built  = 0;
    int            bytes_offered  = 0;
    int            bytes_taken    = 0;
    int            mismatch_count = 0;
    int            records_seen   = 0;
    int            quiet_cycles   = 0;

    string policy_words[7] = '{"none", "quarantine", "reject", "rejectx", "", "n one",
                               "quarantines"};
    string align_words[5]  = '{"s", "r", "S", "ss", ""};

    // ------------------------------------------------------------------
    // Parser predictor
    // ------------------------------------------------------------------
    scan_phase_t scan_phase;
    int          ver_hits;
    logic        ver_bad;
    logic [7:0]  tag_name[5];
    int          tag_name_len;
    logic [7:0]  tag_value[10];
    int          tag_value_len;
    logic [1:0]  tag_overflow;    // bit0 name, bit1 value
    int          pct_sum;         // PCT_BAD once the value is no percentage
    logic        gap_space;       // whitespace seen after kept characters
    logic [2:0]  p_class;
    logic [2:0]  sp_class;
    logic        dkim_s;
    logic        spf_s;
    logic [6:0]  pct_kept;
    logic        record_ok;
    dmarc_result_t parsed;

    function automatic logic ws_char(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c | 8'h20;
        return c;
    endfunction

    function automatic logic name_matches(input string kw);
        if (tag_overflow[0] || tag_name_len != kw.len())
            return 1'b0;
        for (int i = 0; i < tag_name_len; i++)
            if (tag_name[i] != kw[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic value_matches(input string kw);
        if (tag_overflow[1] || tag_value_len != kw.len())
            return 1'b0;
        for (int i = 0; i < tag_value_len; i++)
            if (fold_case(tag_value[i]) != kw[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [2:0] policy_of();
        if (value_matches("none"))
            return CLS_NONE;
        if (value_matches("quarantine"))
            return CLS_QUAR;
        if (value_matches("reject"))
            return CLS_REJECT;
        return CLS_INVALID;
    endfunction

    function automatic void clear_tag_token();
        tag_name_len  = 0;
        tag_value_len = 0;
        tag_overflow  = 2'b00;
        pct_sum       = 0;
        gap_space     = 1'b0;
    endfunction

    function automatic void reset_record();
        scan_phase = PH_VERSION;
        ver_hits   = 0;
        ver_bad    = 1'b0;
        clear_tag_token();
        p_class    = CLS_ABSENT;
        sp_class   = CLS_ABSENT;
        dkim_s     = 1'b0;
        spf_s      = 1'b0;
        pct_kept   = PCT_DEFAULT;
    endfunction

    // A semicolon or the last byte closes the open token
    function automatic void close_tag_token();
        case (scan_phase)
            PH_VERSION:
                if (ver_hits != int'(VERSION_LEN))
                    ver_bad = 1'b1;
            PH_VALUE:
                if (name_matches("p"))
                    p_class = policy_of();
                else if (name_matches("sp"))
                    sp_class = policy_of();
                else if (name_matches("adkim"))
                    dkim_s = value_matches("s");
                else if (name_matches("aspf"))
                    spf_s = value_matches("s");
                else if (name_matches("pct"))
                    pct_kept = (tag_value_len > 0 && pct_sum <= int'(PCT_MAX)) ?
                               7'(pct_sum) : PCT_DEFAULT;
            default: ;
        endcase
        scan_phase = PH_NAME;
        clear_tag_token();
    endfunction

    function automatic void scan_text_byte(input logic [7:0] c);
        if (c == CH_SEMI)
        begin
            close_tag_token();
            return;
        end
        case (scan_phase)
            PH_VERSION:
                if (!ws_char(c))
                begin
                    if (ver_hits < int'(VERSION_LEN) && c == VERSION_TEXT[63 - 8*ver_hits -: 8])
                        ver_hits++;
                    else
                        ver_bad = 1'b1;
                end
            PH_NAME:
                if (c == CH_EQUALS)
                begin
                    scan_phase = PH_VALUE;
                    gap_space  = 1'b0;
                end
                else if (ws_char(c))
                begin
                    if (tag_name_len > 0)
                        gap_space = 1'b1;
                end
                else if (gap_space || tag_name_len >= int'(NAME_CAP))
                    tag_overflow[0] = 1'b1;
                else
                begin
                    tag_name[tag_name_len] = fold_case(c);
                    tag_name_len++;
                end
            default:
                if (ws_char(c))
                begin
                    if (tag_value_len > 0)
                        gap_space = 1'b1;
                end
                else
                begin
                    if (gap_space)
                    begin
                        tag_overflow[1] = 1'b1;
                        pct_sum = PCT_BAD;
                    end
                    // percentage judged digit by digit, independent of the buffer
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        if (pct_sum <= int'(PCT_MAX))
                        begin
                            pct_sum = pct_sum * 10 + int'(c - CH_ZERO);
                            if (pct_sum > int'(PCT_MAX))
                                pct_sum = PCT_BAD;
                        end
                    end
                    else
                        pct_sum = PCT_BAD;
                    if (tag_value_len < int'(VALUE_CAP))
                    begin
                        tag_value[tag_value_len] = c;
                        tag_value_len++;
                    end
                    else
                        tag_overflow[1] = 1'b1;
                end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Record builders
    // ------------------------------------------------------------------
    task automatic add_raw(input logic [7:0] c);
        draft.push_back(c);
    endtask

    // Letters optionally get a random case
    task automatic add_text(input string s, input logic mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                $urandom_range(0, 1))
                c = c ^ 8'h20;
            draft.push_back(c);
        end
    endtask

    task automatic add_ws(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0:       draft.push_back(CH_TAB);
                1:       draft.push_back(CH_CR);
                2:       draft.push_back(CH_LF);
                default: draft.push_back(CH_SPACE);
            endcase
        end
    endtask

    task automatic commit_record(input logic wait_idle);
        text_item_t item;
        for (int i = 0; i < draft.size(); i++)
        begin
            item.text      = draft[i];
            item.last      = (i == draft.size() - 1);
            item.wait_idle = wait_idle && (i == 0);
            text_backlog.push_back(item);
        end
        draft.delete();
        records_built++;
    endtask

    task automatic add_random_tag();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        add_ws(1);
        case (kind)
            0, 1:    add_text("p", 1'b1);
            2:       add_text("sp", 1'b1);
            3:       add_text("adkim", 1'b1);
            4:       add_text("aspf", 1'b1);
            5, 6:    add_text("pct", 1'b1);
            7:       add_text("rua", 1'b0);
            8:       add_text("adkimx", 1'b0);
            default: add_text("junk", 1'b0);   // token without an equals sign
        endcase
        add_ws(1);
        if (kind == 9)
            return;
        add_raw(CH_EQUALS);
        add_ws(1);
        case (kind)
            0, 1, 2:
                add_text(policy_words[($urandom_range(0, 3) == 0) ?
                         $urandom_range(3, 6) : $urandom_range(0, 2)], 1'b1);
            3, 4, 8:
                add_text(align_words[$urandom_range(0, 4)], 1'b1);
            5, 6:
                if ($urandom_range(0, 5) == 0)
                begin
                    if ($urandom_range(0, 1))
                        add_text("-5", 1'b0);
                    else
                        add_text("4 2", 1'b0);
                end
                else
                begin
                    n = $urandom_range(0, 3);
                    if ($urandom_range(0, 3) == 0)
                        repeat (n) add_raw(CH_ZERO);
                    add_text($sformatf("%0d", $urandom_range(0, 130)), 1'b0);
                end
            default:
                add_text("mailto:x", 1'b0);
        endcase
        add_ws(1);
    endtask

    task automatic build_random_record();
        int n;
        if ($urandom_range(0, 99) < 12)
        begin
            // noise record
            n = $urandom_range(1, 24);
            repeat (n) add_raw(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_ws(2);
            case ($urandom_range(0, 19))
                0:       add_text("v=DMARC2", 1'b0);
                1:       add_text("v=DMARC1", 1'b1);
                2:       add_text("v=DMARC", 1'b0);
                default:
                    for (int i = 0; i < 8; i++)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            add_ws(1);
                        add_raw(VERSION_TEXT[63 - 8*i -: 8]);
                    end
            endcase
            add_ws(1);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                add_raw(CH_SEMI);
                add_random_tag();
            end
            if ($urandom_range(0, 3) == 0 || draft.size() == 0)
                add_raw(CH_SEMI);
        end
        commit_record(records_built % 8 == 0);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: record %0d %s: got %0d, expected %0d", $time, records_seen, what,
                 got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: byte requests in bursts, result ready on a pattern of its own
    // ------------------------------------------------------------------
    int       burst_left = 1;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       mode_left  = 0;
    int       stall_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (tx_valid && bytes_taken != bytes_offered)
            begin
                // request still waiting for ready
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                tx_valid <= 1'b0;
            end
            else if (text_backlog.size() > 0 &&
                     !(text_backlog[0].wait_idle && expected_records.size() > 0))
            begin
                tx_valid <= 1'b1;
                tx_text  <= text_backlog[0].text;
                tx_last  <= text_backlog[0].last;
                bytes_offered++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                tx_valid <= 1'b0;

            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN: rx_ready <= 1'b1;
                RX_COIN: rx_ready <= 1'($urandom_range(0, 1));
                default:
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rx_ready <= 1'b0;
                    end
                    else
                    begin
                        rx_ready   <= 1'b1;
                        stall_left = $urandom_range(1, 24);
                    end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accepted bytes feed the predictor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && tx_valid && byte_ch.ready)
        begin
            bytes_taken++;
            void'(text_backlog.pop_front());
            scan_text_byte(tx_text);
            if (tx_last)
            begin
                close_tag_token();
                record_ok = !ver_bad && p_class >= CLS_NONE;
                parsed    = '0;
                parsed.percent = PCT_DEFAULT;
                if (record_ok)
                begin
                    parsed.record_valid  = 1'b1;
                    parsed.domain_policy = 2'(p_class - CLS_NONE);
                    if (sp_class >= CLS_NONE)
                    begin
                        parsed.subdomain_policy     = 2'(sp_class - CLS_NONE);
                        parsed.has_subdomain_policy = 1'b1;
                    end
                    parsed.dkim_strict = dkim_s;
                    parsed.spf_strict  = spf_s;
                    parsed.percent     = pct_kept;
                end
                expected_records.push_back(parsed);
                reset_record();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog
    // ------------------------------------------------------------------
    dmarc_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tx_valid && byte_ch.ready) || (result_ch.valid && rx_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (result_ch.valid && rx_ready)
            begin
                if (expected_records.size() == 0)
                    report_mismatch("unexpected record", 1, 0);
                else
                begin
                    want = expected_records.pop_front();
                    check_field("record_valid", result_ch.record_valid, want.record_valid);
                    check_field("domain_policy", result_ch.domain_policy, want.domain_policy);
                    check_field("subdomain_policy", result_ch.subdomain_policy,
                                want.subdomain_policy);
                    check_field("has_subdomain_policy", result_ch.has_subdomain_policy,
                                want.has_subdomain_policy);
                    check_field("dkim_strict", result_ch.dkim_strict, want.dkim_strict);
                    check_field("spf_strict", result_ch.spf_strict, want.spf_strict);
                    check_field("percent", result_ch.percent, want.percent);
                end
                records_seen++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("[dmarc_record_parser] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        reset_record();

        // Valid records covering every tag
        add_text("v=DMARC1; p=none", 1'b0);
        commit_record(1'b0);
        add_text(" v = DMARC1 ;P=Quarantine;sp=REJECT;adkim=s;aspf=S;pct=50", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=reject;sp=bogus;adkim=r;aspf=s;pct=100;", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;sp=none;p=none;adkim=S;aspf=r", 1'b0);
        commit_record(1'b0);
        // Tab, CR and LF inside the version token
        add_text("v=\tDMARC1", 1'b0);
        add_raw(CH_CR);
        add_raw(CH_LF);
        add_text(";p=none", 1'b0);
        commit_record(1'b1);
        // Percent syntax and long values judged digit by digit
        add_text("v=DMARC1;p=none;pct=101", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=none;pct=00000000007", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=none;pct=0;pct=-5", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=none;pct= ;aspf=s", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=quarantine;pct=1 0;adkim=s", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=none;pct=0", 1'b0);
        commit_record(1'b0);
        // Inner whitespace and long names or values match nothing
        add_text("v=DMARC1;p= re ject", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=quarantinex", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=none;a dkim=s;adkimx=s;aspf = s s;foo;bar=1", 1'b0);
        commit_record(1'b0);
        // Last occurrence wins
        add_text("v=DMARC1;p=reject;p=none;adkim=s;adkim=r", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;p=reject;sp=none;pct=20;p=junk", 1'b0);
        commit_record(1'b0);
        // Bad versions and missing policy
        add_text("v=DMARC2;p=none", 1'b0);
        commit_record(1'b0);
        add_text("v=dmarc1;p=none", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1;adkim=s", 1'b0);
        commit_record(1'b0);
        add_text("v=DMARC1p=none", 1'b0);
        commit_record(1'b0);
        // Byte extremes inside an unknown tag
        add_text("v=DMARC1;p=none;x=", 1'b0);
        add_raw(8'h00);
        add_raw(8'hFF);
        add_text(";sp=quarantine", 1'b0);
        commit_record(1'b0);
        // Empty records: a lone last byte
        add_raw("x");
        commit_record(1'b0);
        add_raw(CH_SEMI);
        commit_record(1'b1);

        while (text_backlog.size() < BYTE_TARGET || records_built < RECORD_TARGET)
            build_random_record();

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (text_backlog.size() > 0 || expected_records.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_records.size() == 0)
            $display("[dmarc_record_parser] OK");
        else
            $display("[dmarc_record_parser] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/dmarc_pkg.sv
hw/rtl/dmarc_stream_if.sv
hw/rtl/dmarc_tag_classify.sv
hw/rtl/dmarc_tag_parser.sv
hw/rtl/dmarc_record_parser.sv
sim/tb_dmarc_record_parser.sv
